FILE: rtl/descriptor_slot_allocator_macros.svh
// descriptor_slot_allocator_macros.svh: assertion macros for the slot allocator RTL.
// Depends on nothing; included by modules that carry concurrent assertions.
`ifndef DESCRIPTOR_SLOT_ALLOCATOR_MACROS_SVH
`define DESCRIPTOR_SLOT_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define DSA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DSA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DSA_ASSERT(label, clk, rst, prop, msg)
`define DSA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: rtl/dsa_pkg.sv
// dsa_pkg: types, widths and codes shared by the descriptor slot allocator.
// Depends on nothing; used by descriptor_slot_allocator.
package dsa_pkg;

  localparam int POOL_DEPTH = 1024;
  localparam int SLOT_W     = $clog2(POOL_DEPTH);
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
  localparam int ADDR_W     = 64;
  localparam int STRIDE_W   = 16;
  localparam int PSIZE_W    = 11;
  localparam int PROD_W     = SLOT_W + STRIDE_W;
  // Offsets of legal handles stay below POOL_DEPTH * 2^STRIDE_W
  localparam int SHORT_W    = PROD_W;
  localparam int DIV_CNT_W  = $clog2(ADDR_W + 1);

  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [STRIDE_W-1:0]  stride_t;
  typedef logic [PSIZE_W-1:0]   psize_t;
  typedef logic [PROD_W-1:0]    prod_t;
  typedef logic [DIV_CNT_W-1:0] div_cnt_t;
  typedef logic [1:0]           status_t;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_EMPTY    = 2'd1;
  localparam status_t ST_MISMATCH = 2'd2;
  localparam status_t ST_BAD      = 2'd3;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam stride_t STRIDE_RESET = 16'd32;

  typedef enum logic [1:0] {
    REG_CPU_BASE,
    REG_GPU_BASE,
    REG_STRIDE,
    REG_POOL_SIZE
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC,
    S_POP,
    S_MUL,
    S_ADD,
    S_FREE_CHK,
    S_DIV,
    S_DEC,
    S_RESP
  } state_t;

endpackage

FILE: rtl/descriptor_slot_allocator.sv
// descriptor_slot_allocator: top level of the free-list stack slot allocator.
// Depends on dsa_pkg, dsa_ram and descriptor_slot_allocator_macros.svh.
//
// The allocator handles one transaction at a time. An allocate pops a freed
// slot when the stack holds one, which costs one RAM read, or else takes the
// next fresh slot, then multiplies it by the stride and adds the bases; when
// the pool is empty it returns status empty. A free runs a radix-2 restoring
// division of both handle offsets by the stride, one quotient bit per cycle.
// When both offsets fit in SLOT_W + 16 bits (26 with a 1024-slot pool, true
// for every legal handle) it skips the leading quotient bits, which are zero.
// Frees rejected for a handle below its base or a zero stride skip the
// division. The result is loaded into the output register as the allocator
// returns to idle, where the next transaction can be accepted, even while the
// previous result still waits for out_ready. The freed-slot stack lives in a
// 1024 x 10 RAM with registered read; its contents are never cleared, only
// the stack count, so there is no clearing pass after reset.
// Configuration writes are taken at any time (cfg_ready is tied high) and
// must only be issued while the allocator is idle; writing pool_size empties
// the stack and restarts fresh issue at slot 0.
`include "descriptor_slot_allocator_macros.svh"

module descriptor_slot_allocator (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [63:0]           cfg_data,
  // request channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  dsa_pkg::addr_t        cpu_handle_in,
  input  dsa_pkg::addr_t        gpu_handle_in,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output dsa_pkg::addr_t        cpu_handle_out,
  output dsa_pkg::addr_t        gpu_handle_out,
  output dsa_pkg::status_t      status
);

  // configuration registers
  dsa_pkg::addr_t   cpu_base;
  dsa_pkg::addr_t   gpu_base;
  dsa_pkg::stride_t stride;
  dsa_pkg::psize_t  pool_size;

  // pool bookkeeping
  dsa_pkg::cnt_t    freed_count;
  dsa_pkg::cnt_t    next_fresh;
  dsa_pkg::cnt_t    size;
  dsa_pkg::cnt_t    cnt_dec;

  dsa_pkg::state_t  state;
  dsa_pkg::state_t  state_next;

  // request held for the duration of the transaction
  dsa_pkg::addr_t   cpu_h;
  dsa_pkg::addr_t   gpu_h;

  // allocate datapath
  dsa_pkg::slot_t   slot;
  dsa_pkg::prod_t   prod;

  // divider datapath, one lane per handle
  logic [dsa_pkg::ADDR_W:0] off_a;
  logic [dsa_pkg::ADDR_W:0] off_b;
  logic             off_short;
  logic             chk_bad;
  dsa_pkg::addr_t   dvd_a;
  dsa_pkg::addr_t   dvd_b;
  dsa_pkg::stride_t rem_a;
  dsa_pkg::stride_t rem_b;
  logic [dsa_pkg::STRIDE_W:0] rs_a;
  logic [dsa_pkg::STRIDE_W:0] rs_b;
  logic [dsa_pkg::STRIDE_W:0] stride_x;
  logic             qbit_a;
  logic             qbit_b;
  dsa_pkg::div_cnt_t div_cnt;
  dsa_pkg::cnt_t    q_a;
  logic             q_hi;
  logic             q_diff;

  // decision after the division
  logic             dec_big;
  logic             dec_full;
  logic             dec_push;
  dsa_pkg::status_t dec_status;

  // pending result
  dsa_pkg::addr_t   res_cpu;
  dsa_pkg::addr_t   res_gpu;
  dsa_pkg::status_t res_status;

  // stack RAM
  logic             ram_we;
  dsa_pkg::slot_t   ram_waddr;
  dsa_pkg::slot_t   ram_raddr;
  dsa_pkg::slot_t   ram_rdata;

  logic             cfg_fire;
  logic             cfg_clear;
  logic             out_free;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_clear = cfg_fire && (cfg_index == dsa_pkg::REG_POOL_SIZE);
  assign out_free  = !out_valid || out_ready;

  // Saturate the configured size to the physical pool depth
  assign size = (32'(pool_size) > 32'(dsa_pkg::POOL_DEPTH))
              ? dsa_pkg::cnt_t'(dsa_pkg::POOL_DEPTH)
              : dsa_pkg::cnt_t'(pool_size);
  assign cnt_dec = freed_count - dsa_pkg::cnt_t'(1);

  // Offsets from the bases; the top bit is the borrow (handle below base)
  assign off_a     = {1'b0, cpu_h} - {1'b0, cpu_base};
  assign off_b     = {1'b0, gpu_h} - {1'b0, gpu_base};
  assign chk_bad   = off_a[dsa_pkg::ADDR_W] || off_b[dsa_pkg::ADDR_W] || (stride == '0);
  assign off_short = (off_a[dsa_pkg::ADDR_W-1:dsa_pkg::SHORT_W] == '0)
                  && (off_b[dsa_pkg::ADDR_W-1:dsa_pkg::SHORT_W] == '0);

  // One restoring division step per lane; remainder stays below stride
  assign stride_x = {1'b0, stride};
  assign rs_a     = {rem_a, dvd_a[dsa_pkg::ADDR_W-1]};
  assign rs_b     = {rem_b, dvd_b[dsa_pkg::ADDR_W-1]};
  assign qbit_a   = rs_a >= stride_x;
  assign qbit_b   = rs_b >= stride_x;

  // Free checks in priority order: slots differ, slot outside pool, stack full
  assign dec_big    = q_hi || (q_a >= size);
  assign dec_full   = freed_count >= size;
  assign dec_push   = !q_diff && !dec_big && !dec_full;
  assign dec_status = q_diff ? dsa_pkg::ST_MISMATCH
                    : (dec_big || dec_full) ? dsa_pkg::ST_BAD : dsa_pkg::ST_OK;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_base  <= '0;
      gpu_base  <= '0;
      stride    <= dsa_pkg::STRIDE_RESET;
      pool_size <= dsa_pkg::psize_t'(dsa_pkg::POOL_DEPTH);
    end else if (cfg_fire) begin
      case (cfg_index)
        dsa_pkg::REG_CPU_BASE:  cpu_base  <= cfg_data;
        dsa_pkg::REG_GPU_BASE:  gpu_base  <= cfg_data;
        dsa_pkg::REG_STRIDE:    stride    <= cfg_data[dsa_pkg::STRIDE_W-1:0];
        dsa_pkg::REG_POOL_SIZE: pool_size <= cfg_data[dsa_pkg::PSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, handshake and RAM control
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = freed_count[dsa_pkg::SLOT_W-1:0];
    ram_raddr  = cnt_dec[dsa_pkg::SLOT_W-1:0];
    case (state)
      dsa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (req_type == dsa_pkg::REQ_FREE) ? dsa_pkg::S_FREE_CHK
                                                       : dsa_pkg::S_ALLOC;
        end
      end
      dsa_pkg::S_ALLOC: begin
        if (freed_count != '0) begin
          state_next = dsa_pkg::S_POP;
        end else if (next_fresh < size) begin
          state_next = dsa_pkg::S_MUL;
        end else begin
          state_next = dsa_pkg::S_RESP;
        end
      end
      dsa_pkg::S_POP:      state_next = dsa_pkg::S_MUL;
      dsa_pkg::S_MUL:      state_next = dsa_pkg::S_ADD;
      dsa_pkg::S_ADD:      state_next = dsa_pkg::S_RESP;
      dsa_pkg::S_FREE_CHK: state_next = chk_bad ? dsa_pkg::S_RESP : dsa_pkg::S_DIV;
      dsa_pkg::S_DIV: begin
        if (div_cnt == dsa_pkg::div_cnt_t'(1)) begin
          state_next = dsa_pkg::S_DEC;
        end
      end
      dsa_pkg::S_DEC: begin
        ram_we     = dec_push;
        state_next = dsa_pkg::S_RESP;
      end
      dsa_pkg::S_RESP: begin
        if (out_free) begin
          state_next = dsa_pkg::S_IDLE;
        end
      end
      default: state_next = dsa_pkg::S_IDLE;
    endcase
  end

  // Stack count and fresh pointer; a pool_size write clears both
  always_ff @(posedge clk) begin
    if (rst) begin
      freed_count <= '0;
      next_fresh  <= '0;
    end else if (cfg_clear) begin
      freed_count <= '0;
      next_fresh  <= '0;
    end else begin
      if (state == dsa_pkg::S_ALLOC) begin
        if (freed_count != '0) begin
          freed_count <= cnt_dec;
        end else if (next_fresh < size) begin
          next_fresh <= next_fresh + dsa_pkg::cnt_t'(1);
        end
      end
      if (ram_we) begin
        freed_count <= freed_count + dsa_pkg::cnt_t'(1);
      end
    end
  end

  // Payload datapath
  always_ff @(posedge clk) begin
    case (state)
      dsa_pkg::S_IDLE: begin
        if (in_valid) begin
          cpu_h    <= cpu_handle_in;
          gpu_h    <= gpu_handle_in;
        end
      end
      dsa_pkg::S_ALLOC: begin
        // Fresh slot is below size, so it fits the slot width
        slot       <= next_fresh[dsa_pkg::SLOT_W-1:0];
        res_cpu    <= '0;
        res_gpu    <= '0;
        res_status <= dsa_pkg::ST_EMPTY;
      end
      dsa_pkg::S_POP: slot <= ram_rdata;
      dsa_pkg::S_MUL: prod <= dsa_pkg::prod_t'(slot) * dsa_pkg::prod_t'(stride);
      dsa_pkg::S_ADD: begin
        res_cpu    <= cpu_base + dsa_pkg::addr_t'(prod);
        res_gpu    <= gpu_base + dsa_pkg::addr_t'(prod);
        res_status <= dsa_pkg::ST_OK;
      end
      dsa_pkg::S_FREE_CHK: begin
        res_cpu    <= '0;
        res_gpu    <= '0;
        res_status <= dsa_pkg::ST_BAD;
        rem_a      <= '0;
        rem_b      <= '0;
        q_a        <= '0;
        q_hi       <= 1'b0;
        q_diff     <= 1'b0;
        // Skip leading quotient bits that are known zero for short offsets
        if (off_short) begin
          dvd_a   <= off_a[dsa_pkg::ADDR_W-1:0] << (dsa_pkg::ADDR_W - dsa_pkg::SHORT_W);
          dvd_b   <= off_b[dsa_pkg::ADDR_W-1:0] << (dsa_pkg::ADDR_W - dsa_pkg::SHORT_W);
          div_cnt <= dsa_pkg::div_cnt_t'(dsa_pkg::SHORT_W);
        end else begin
          dvd_a   <= off_a[dsa_pkg::ADDR_W-1:0];
          dvd_b   <= off_b[dsa_pkg::ADDR_W-1:0];
          div_cnt <= dsa_pkg::div_cnt_t'(dsa_pkg::ADDR_W);
        end
      end
      dsa_pkg::S_DIV: begin
        rem_a   <= qbit_a ? dsa_pkg::stride_t'(rs_a - stride_x) : rs_a[dsa_pkg::STRIDE_W-1:0];
        rem_b   <= qbit_b ? dsa_pkg::stride_t'(rs_b - stride_x) : rs_b[dsa_pkg::STRIDE_W-1:0];
        dvd_a   <= dvd_a << 1;
        dvd_b   <= dvd_b << 1;
        // Keep the low quotient bits; any bit shifted out marks a huge slot
        q_a     <= {q_a[dsa_pkg::CNT_W-2:0], qbit_a};
        q_hi    <= q_hi | q_a[dsa_pkg::CNT_W-1];
        q_diff  <= q_diff | (qbit_a ^ qbit_b);
        div_cnt <= div_cnt - dsa_pkg::div_cnt_t'(1);
      end
      dsa_pkg::S_DEC: res_status <= dec_status;
      default: ;
    endcase
  end

  // Output register: load when empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == dsa_pkg::S_RESP && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == dsa_pkg::S_RESP && out_free) begin
      cpu_handle_out <= res_cpu;
      gpu_handle_out <= res_gpu;
      status         <= res_status;
    end
  end

  dsa_ram #(
    .WIDTH (dsa_pkg::SLOT_W),
    .DEPTH (dsa_pkg::POOL_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_a[dsa_pkg::SLOT_W-1:0]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  `DSA_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> (freed_count == '0 && next_fresh == '0 && !out_valid && state == dsa_pkg::S_IDLE), "reset left pool state behind")
  `DSA_ASSERT(a_stack_bound, clk, rst, freed_count <= size, "stack count exceeds pool size")
  `DSA_ASSERT(a_push_counts, clk, rst, (ram_we && !cfg_clear) |=> (freed_count == $past(freed_count) + dsa_pkg::cnt_t'(1)), "push did not grow the stack")
  `DSA_ASSERT(a_accept_busy, clk, rst, (in_valid && in_ready) |=> !in_ready, "second transaction taken while busy")
  `DSA_ASSERT(a_empty_zero, clk, rst, (out_valid && status == dsa_pkg::ST_EMPTY) |-> (cpu_handle_out == '0 && gpu_handle_out == '0), "failed allocate returned a handle")

endmodule

FILE: rtl/dsa_ram.sv
// dsa_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing; instanced by descriptor_slot_allocator.
module dsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
